@@ design/scs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package scs_pkg;
  localparam int MaxSlides = 16;
  localparam int IdxW = 4;
  localparam int TimeW = 27;
  localparam int ElapW = 32;
  localparam int AlphaW = 17;
  localparam logic [AlphaW-1:0] AlphaOne = 17'h10000;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SKIP = 2'd1,
    ACT_LOAD = 2'd2,
    ACT_START = 2'd3
  } action_t;

  localparam logic [0:0] REG_COUNT = 1'b0;
  localparam logic [0:0] REG_LOCKOUT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch input item
    logic clr_sum;     // advance elapsed for tick or skip
    logic sum_step;    // add table entry i to total
    logic sum_done;    // commit total and prepare step
    logic walk_init;   // begin slide walk
    logic walk_step;   // examine slide i
    logic div_init;    // begin fraction division
    logic div_step;    // one quotient bit
    logic div_done;    // commit alpha
    logic out_load;    // present result
  } scs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic n_zero;      // no slides in use
    logic last_i;      // index at last slide
    logic need_refresh;// tick/skip will change state
    logic at_end;      // elapsed at or past total
    logic hit;         // slide i covers elapsed
    logic need_div;    // fraction non-trivial
    logic div_last;    // final quotient bit
  } scs_sts_t;
endpackage
`default_nettype wire

@@ design/scs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/scs_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scs_datapath import scs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scs_cmd_t          cmd,
  output scs_sts_t               sts,
  input  wire logic [1:0]        in_action,
  input  wire logic [IdxW-1:0]   in_slide_number,
  input  wire logic [TimeW-1:0]  in_hold_time,
  input  wire logic [TimeW-1:0]  in_fade_time,
  input  wire logic [19:0]       in_delta_time,
  input  wire logic [4:0]        slide_count,
  input  wire logic [ElapW-1:0]  skip_lockout,
  output logic [IdxW-1:0]        out_slide_index,
  output logic                   out_slide_valid,
  output logic [AlphaW-1:0]      out_blend_alpha,
  output logic                   out_finished,
  output logic                   out_skip_done
);
  logic [1:0]       act_r;
  logic [19:0]      delta_r;
  logic [ElapW-1:0] elapsed_r, total_r, sum_r, start_r;
  logic             done_r, valid_r, skipped_r;
  logic [IdxW-1:0]  cur_r, i_r;
  logic [AlphaW-1:0] alpha_r;
  logic [TimeW-1:0] hold_q, fade_q;
  logic [43:0]      rem_r;
  logic [AlphaW-1:0] quo_r;
  logic [4:0]       dcnt_r;
  logic [TimeW-1:0] dhold_r, dfade_r;
  logic [ElapW:0]   into_r;

  logic [4:0] n_used;
  assign n_used = (slide_count > 5'(MaxSlides)) ? 5'(MaxSlides) : slide_count;
  logic [IdxW-1:0] last_idx;
  assign last_idx = IdxW'(n_used - 5'd1);

  logic we;
  assign we = cmd.capture && (in_action == ACT_LOAD);

  scs_ram #(.Width(TimeW), .Depth(MaxSlides)) u_hold (
    .clk, .we, .waddr(in_slide_number), .wdata(in_hold_time),
    .raddr(i_r), .rdata(hold_q));
  scs_ram #(.Width(TimeW), .Depth(MaxSlides)) u_fade (
    .clk, .we, .waddr(in_slide_number), .wdata(in_fade_time),
    .raddr(i_r), .rdata(fade_q));

  logic [ElapW:0] end_w, sum_w, el_add;
  assign end_w = {1'b0, start_r} + (ElapW+1)'(hold_q) + (ElapW+1)'(fade_q);
  assign sum_w = {1'b0, sum_r} + (ElapW+1)'(hold_q) + (ElapW+1)'(fade_q);
  assign el_add = {1'b0, elapsed_r} + (ElapW+1)'(delta_r);

  logic [43:0] trial;
  assign trial = {rem_r[42:0], 1'b0};

  // status
  assign sts.action = act_r;
  assign sts.n_zero = (n_used == 5'd0);
  assign sts.last_i = (i_r == last_idx);
  assign sts.need_refresh = !done_r &&
    ((act_r == ACT_TICK) || (act_r == ACT_SKIP && elapsed_r >= skip_lockout));
  assign sts.at_end = (elapsed_r >= total_r);
  assign sts.hit = ({1'b0, elapsed_r} < end_w);
  assign sts.need_div = (fade_q != '0) &&
    (({1'b0, elapsed_r} - {1'b0, start_r}) > (ElapW+1)'(hold_q));
  assign sts.div_last = (dcnt_r == 5'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0; total_r <= '0; done_r <= 1'b1; cur_r <= '0;
      valid_r <= 1'b0; alpha_r <= '0; i_r <= '0; skipped_r <= 1'b0;
    end else begin
      // hold item
      if (cmd.capture) begin
        act_r <= in_action;
        delta_r <= in_delta_time; skipped_r <= 1'b0;
        i_r <= '0;
        if (in_action == ACT_START) begin
          elapsed_r <= '0; alpha_r <= '0; cur_r <= '0; valid_r <= 1'b0;
          total_r <= '0; sum_r <= '0; done_r <= 1'b1;
        end
      end
      // advance elapsed for tick or skip
      if (cmd.clr_sum) begin
        if (act_r == ACT_TICK)
          elapsed_r <= el_add[ElapW] ? '1 : el_add[ElapW-1:0];
        else begin
          elapsed_r <= total_r; skipped_r <= 1'b1;
        end
      end
      // accumulate total
      if (cmd.sum_step) begin
        sum_r <= sum_w[ElapW] ? '1 : sum_w[ElapW-1:0];
        i_r <= i_r + IdxW'(1);
      end
      if (cmd.sum_done) begin
        total_r <= sum_r; done_r <= (sum_r == '0); valid_r <= 1'b1;
      end
      // walk slides
      if (cmd.walk_init) begin
        i_r <= '0; start_r <= '0;
        if (n_used == 5'd0) begin
          done_r <= 1'b1; alpha_r <= AlphaOne;
        end else if (elapsed_r >= total_r) begin
          done_r <= 1'b1; cur_r <= last_idx; valid_r <= 1'b1; alpha_r <= AlphaOne;
        end
      end
      if (cmd.walk_step) begin
        if ({1'b0, elapsed_r} < end_w) begin
          cur_r <= i_r; valid_r <= 1'b1;
          into_r <= {1'b0, elapsed_r} - {1'b0, start_r};
          dhold_r <= hold_q; dfade_r <= fade_q;
          alpha_r <= '0;
        end else if (i_r == last_idx) begin
          done_r <= 1'b1; cur_r <= last_idx; valid_r <= 1'b1; alpha_r <= AlphaOne;
        end else begin
          start_r <= end_w[ElapW-1:0]; i_r <= i_r + IdxW'(1);
        end
      end
      // restoring division, one bit a cycle
      if (cmd.div_init) begin
        rem_r <= 44'(into_r - (ElapW+1)'(dhold_r));
        quo_r <= '0; dcnt_r <= 5'd16;
      end
      if (cmd.div_step) begin
        if (dcnt_r == 5'd16) begin
          if (rem_r >= 44'(dfade_r)) begin
            quo_r <= {quo_r[AlphaW-2:0], 1'b1}; rem_r <= rem_r - 44'(dfade_r);
          end else quo_r <= {quo_r[AlphaW-2:0], 1'b0};
        end else if (trial >= 44'(dfade_r)) begin
          quo_r <= {quo_r[AlphaW-2:0], 1'b1}; rem_r <= trial - 44'(dfade_r);
        end else begin
          quo_r <= {quo_r[AlphaW-2:0], 1'b0}; rem_r <= trial;
        end
        dcnt_r <= dcnt_r - 5'd1;
      end
      if (cmd.div_done)
        alpha_r <= (quo_r > AlphaOne) ? AlphaOne : quo_r;
      // present result
      if (cmd.out_load) begin
        out_slide_index <= cur_r; out_slide_valid <= valid_r;
        out_blend_alpha <= alpha_r; out_finished <= done_r;
        out_skip_done <= skipped_r;
      end
    end
  end
endmodule
`default_nettype wire

@@ design/scs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scs_ctrl import scs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output scs_cmd_t      cmd,
  input  wire scs_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SUMRD, S_SUM, S_WALKINIT, S_WALKRD, S_WALK,
    S_DIVINIT, S_DIV, S_DIVDONE, S_OUT, S_WAIT
  } state_t;
  state_t state_r, state_nxt;
  logic ov_r, ov_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ov_nxt = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.capture = 1'b1; state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.action)
          ACT_LOAD: state_nxt = S_OUT;
          ACT_START: state_nxt = sts.n_zero ? S_OUT : S_SUMRD;
          default: if (sts.need_refresh) begin
            cmd.clr_sum = 1'b1; state_nxt = S_WALKINIT;
          end else state_nxt = S_OUT;
        endcase
      end
      S_SUMRD: state_nxt = S_SUM;
      S_SUM: begin
        cmd.sum_step = 1'b1;
        state_nxt = sts.last_i ? S_WALKINIT : S_SUMRD;
        if (sts.last_i) cmd.sum_done = 1'b0;
      end
      S_WALKINIT: begin
        if (sts.action == ACT_START) cmd.sum_done = 1'b1;
        state_nxt = S_WALKRD;
      end
      S_WALKRD: begin
        if (sts.action == ACT_START) begin
          cmd.walk_init = 1'b1;
          state_nxt = (sts.n_zero || sts.at_end) ? S_OUT : S_WALK;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt = (sts.n_zero || sts.at_end) ? S_OUT : S_WALK;
        end
      end
      S_WALK: begin
        state_nxt = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.walk_step = 1'b1;
        if (sts.hit) state_nxt = sts.need_div ? S_DIV : S_OUT;
        else state_nxt = sts.last_i ? S_OUT : S_WALK;
        if (sts.hit && sts.need_div) cmd.div_init = 1'b0;
      end
      S_DIV: begin
        cmd.div_init = 1'b1; state_nxt = S_DIVDONE;
      end
      S_DIVDONE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        cmd.div_done = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: if (!ov_r || out_ready) begin
        cmd.out_load = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

@@ design/slide_crossfade_sequencer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Slide sequencer: load, start, tick and skip items each give one result.
// A load, or a tick or skip that changes nothing, goes from decode straight to
// the result. A start sums the table slide by slide, then walks; a tick or skip
// walks the slides (registered table read) and, if the slide found is in its
// fade, runs a divider of 17 one-bit steps with a set-up step before and a
// commit step after. The result may then wait for out_ready. One item is in
// work at a time.
module slide_crossfade_sequencer_unit import scs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_action,
  input  wire logic [IdxW-1:0]   in_slide_number,
  input  wire logic [TimeW-1:0]  in_hold_time,
  input  wire logic [TimeW-1:0]  in_fade_time,
  input  wire logic [19:0]       in_delta_time,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IdxW-1:0]        out_slide_index,
  output logic                   out_slide_valid,
  output logic [AlphaW-1:0]      out_blend_alpha,
  output logic                   out_finished,
  output logic                   out_skip_done,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:2]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  logic [4:0]  count_r;
  logic [31:0] lock_r;
  scs_cmd_t cmd;
  scs_sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_LOCKOUT) ? lock_r : {27'd0, count_r};

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; lock_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_COUNT) count_r <= cfg_pwdata[4:0];
      else lock_r <= cfg_pwdata;
    end
  end

  scs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts);

  scs_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_action, .in_slide_number, .in_hold_time,
    .in_fade_time, .in_delta_time, .slide_count(count_r), .skip_lockout(lock_r),
    .out_slide_index, .out_slide_valid, .out_blend_alpha, .out_finished,
    .out_skip_done);
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import scs_pkg::*;

  localparam int StallLimit = 3000;
  localparam int HoldOffCycles = 400;

  typedef struct packed {
    logic [IdxW-1:0]   slide_index;
    logic              slide_valid;
    logic [AlphaW-1:0] blend_alpha;
    logic              finished;
    logic              skip_done;
  } slide_result_t;

  // Slide timing predictor and queue of pending results
  class slide_scoreboard;
    bit [TimeW-1:0]  hold_tbl[MaxSlides];
    bit [TimeW-1:0]  fade_tbl[MaxSlides];
    bit [31:0]       elapsed;
    bit [31:0]       total;
    bit              done = 1'b1;
    bit [IdxW-1:0]   cur_slide;
    bit              cur_valid;
    bit [AlphaW-1:0] cur_alpha;
    bit [4:0]        slide_count;
    bit [31:0]       skip_lockout;
    slide_result_t   pending[$];
    int              errors;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(logic [0:0] idx, bit [31:0] val);
      if (idx == REG_COUNT) slide_count = val[4:0];
      else skip_lockout = val;
    endfunction

    function int unsigned used_slides();
      return (slide_count > MaxSlides) ? MaxSlides : slide_count;
    endfunction

    function void finish_on_last(int unsigned n);
      done = 1'b1;
      cur_slide = IdxW'(n - 1);
      cur_valid = 1'b1;
      cur_alpha = AlphaOne;
    endfunction

    // Locate the slide covering the elapsed time and its crossfade fraction
    function void locate();
      int unsigned n;
      longint unsigned base, stop, into, frac;
      n = used_slides();
      base = 0;
      if (n == 0) begin
        done = 1'b1;
        cur_alpha = AlphaOne;
        return;
      end
      if (elapsed >= total) begin
        finish_on_last(n);
        return;
      end
      for (int i = 0; i < n; i++) begin
        stop = base + hold_tbl[i] + fade_tbl[i];
        if (elapsed < stop) begin
          into = elapsed - base;
          cur_slide = IdxW'(i);
          cur_valid = 1'b1;
          if (fade_tbl[i] != 0 && into > hold_tbl[i]) begin
            frac = ((into - hold_tbl[i]) << 16) / fade_tbl[i];
            cur_alpha = (frac > AlphaOne) ? AlphaOne : AlphaW'(frac);
          end else begin
            cur_alpha = '0;
          end
          return;
        end
        base = stop;
      end
      finish_on_last(n);
    endfunction

    function void note_item(action_t act, bit [IdxW-1:0] num, bit [TimeW-1:0] hold,
                            bit [TimeW-1:0] fade, bit [19:0] delta);
      slide_result_t r;
      longint unsigned sum;
      int unsigned n;
      bit skipped;
      skipped = 1'b0;
      case (act)
        ACT_TICK: begin
          if (!done) begin
            sum = longint'(elapsed) + delta;
            elapsed = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            locate();
          end
        end
        ACT_SKIP: begin
          if (!done && elapsed >= skip_lockout) begin
            elapsed = total;
            locate();
            skipped = 1'b1;
          end
        end
        ACT_LOAD: begin
          hold_tbl[num] = hold;
          fade_tbl[num] = fade;
        end
        default: begin
          n = used_slides();
          elapsed = '0;
          cur_alpha = '0;
          cur_slide = '0;
          cur_valid = 1'b0;
          total = '0;
          if (n == 0) begin
            done = 1'b1;
          end else begin
            sum = 0;
            for (int i = 0; i < n; i++) begin
              sum += longint'(hold_tbl[i]) + fade_tbl[i];
              if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
            end
            total = sum[31:0];
            done = (total == 0);
            cur_valid = 1'b1;
            locate();
          end
        end
      endcase
      r = '{cur_slide, cur_valid, cur_alpha, done, skipped};
      pending.push_back(r);
    endfunction

    task check_result(slide_result_t got);
      slide_result_t exp_r;
      if (pending.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      exp_r = pending.pop_front();
      if (got.slide_index !== exp_r.slide_index)
        report($sformatf("slide_index %0d, want %0d", got.slide_index, exp_r.slide_index));
      if (got.slide_valid !== exp_r.slide_valid)
        report($sformatf("slide_valid %0b, want %0b", got.slide_valid, exp_r.slide_valid));
      if (got.blend_alpha !== exp_r.blend_alpha)
        report($sformatf("blend_alpha %0d, want %0d", got.blend_alpha, exp_r.blend_alpha));
      if (got.finished !== exp_r.finished)
        report($sformatf("finished %0b, want %0b", got.finished, exp_r.finished));
      if (got.skip_done !== exp_r.skip_done)
        report($sformatf("skip_done %0b, want %0b", got.skip_done, exp_r.skip_done));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_action = '0;
  logic [IdxW-1:0]   in_slide_number = '0;
  logic [TimeW-1:0]  in_hold_time = '0;
  logic [TimeW-1:0]  in_fade_time = '0;
  logic [19:0]       in_delta_time = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [IdxW-1:0]   out_slide_index;
  logic              out_slide_valid;
  logic [AlphaW-1:0] out_blend_alpha;
  logic              out_finished;
  logic              out_skip_done;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [2:2]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  slide_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off_req;
  int  hold_off_left;
  int  quiet_cycles;
  int  items_sent;

  slide_crossfade_sequencer_unit uut (.*);

  always #5 clk = ~clk;

  // Check results and pace the receiver, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result('{out_slide_index, out_slide_valid, out_blend_alpha,
                          out_finished, out_skip_done});
      if (hold_off_req && hold_off_left == 0) begin
        hold_off_req = 1'b0;
        hold_off_left = HoldOffCycles;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one item and hold it until accepted
  task send_item(action_t act, bit [IdxW-1:0] num, bit [TimeW-1:0] hold,
                 bit [TimeW-1:0] fade, bit [19:0] delta);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_slide_number <= num;
    in_hold_time <= hold;
    in_fade_time <= fade;
    in_delta_time <= delta;
    do @(posedge clk); while (!in_ready);
    sb.note_item(act, num, hold, fade, delta);
    items_sent++;
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // Register write: setup then access cycle
  task write_reg(logic [0:0] idx, bit [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= idx;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function bit [TimeW-1:0] pick_time(bit wide);
    if ($urandom_range(0, 9) == 0) return '0;
    if (wide) return ($urandom_range(0, 7) == 0) ? TimeW'($urandom) : TimeW'($urandom_range(0, 1 << 22));
    return TimeW'($urandom_range(1, 3000));
  endfunction

  // Mostly well-formed runs: reload a few, start, tick through, maybe skip
  task run_random(int target);
    bit wide;
    int n;
    int ticks;
    bit [19:0] delta;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item(action_t'($urandom_range(0, 3)), IdxW'($urandom), TimeW'($urandom),
                  TimeW'($urandom), 20'($urandom));
        continue;
      end
      wide = ($urandom_range(0, 4) == 0);
      n = sb.used_slides();
      repeat ($urandom_range(0, 4))
        send_item(ACT_LOAD, IdxW'($urandom_range(0, (n > 0) ? n - 1 : 15)),
                  pick_time(wide), pick_time(wide), '0);
      send_item(ACT_START, IdxW'($urandom), TimeW'($urandom), TimeW'($urandom), 20'($urandom));
      ticks = 0;
      while (!sb.done && ticks < 60) begin
        delta = wide ? 20'($urandom) : 20'($urandom_range(0, 2000));
        if ($urandom_range(0, 19) == 0) delta = '1;
        case ($urandom_range(0, 19))
          0: send_item(ACT_SKIP, IdxW'($urandom), TimeW'($urandom), TimeW'($urandom), delta);
          1: send_item(ACT_LOAD, IdxW'($urandom_range(0, 15)), pick_time(wide),
                       pick_time(wide), delta);
          default: send_item(ACT_TICK, IdxW'($urandom), TimeW'($urandom), TimeW'($urandom),
                             delta);
        endcase
        ticks++;
      end
      if (!sb.done && $urandom_range(0, 1))
        send_item(ACT_SKIP, '0, '0, '0, '0);
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No slides: start, tick and skip all see a finished sequence
    send_item(ACT_START, '0, '0, '0, '0);
    send_item(ACT_TICK, '0, '0, '0, '1);
    send_item(ACT_SKIP, '0, '0, '0, '0);

    // Fill the whole table: zero entry, zero fade, full-scale entry
    send_item(ACT_LOAD, 4'd0, '0, '0, '0);
    send_item(ACT_LOAD, 4'd1, TimeW'(100), '0, '0);
    send_item(ACT_LOAD, 4'd2, '1, '1, '0);
    for (int i = 3; i < MaxSlides; i++)
      send_item(ACT_LOAD, IdxW'(i), TimeW'(50 * i), TimeW'(200 + i), '0);

    // One slide with zero total: finished at once on it
    drain();
    write_reg(REG_COUNT, 32'd1);
    send_item(ACT_START, '0, '0, '0, '0);

    // Full table with lockout: skip refused, then allowed
    send_item(ACT_LOAD, 4'd0, TimeW'(1000), TimeW'(3000), '0);
    drain();
    write_reg(REG_COUNT, 32'd16);
    write_reg(REG_LOCKOUT, 32'hFFFF_FFFF);
    send_item(ACT_START, '0, '0, '0, '0);
    send_item(ACT_TICK, '0, '0, '0, 20'd1100);
    send_item(ACT_TICK, '0, '0, '0, 20'd1500);
    send_item(ACT_SKIP, '0, '0, '0, '0);
    drain();
    write_reg(REG_LOCKOUT, 32'd0);
    send_item(ACT_SKIP, '0, '0, '0, '0);

    // Sender idles lightly, receiver heavily
    send_idle_pct = 23;
    recv_idle_pct = 69;
    run_random(560);

    drain();
    write_reg(REG_COUNT, $urandom_range(1, 16));
    write_reg(REG_LOCKOUT, $urandom_range(0, 5000));
    send_idle_pct = 69;
    recv_idle_pct = 23;
    run_random(1100);

    drain();
    write_reg(REG_COUNT, $urandom_range(0, 16));
    write_reg(REG_LOCKOUT, $urandom_range(0, 1500));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = 1'b1;
    run_random(1650);

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
